// ===== rtl/abrt_pkg.sv =====
// Package for the alpha-beta range tracker: word types, register map and reset values.
// No dependencies.
`default_nettype none

package abrt_pkg;

    localparam int ADDR_W = 5;
    localparam int DATA_W = 32;

    localparam logic [2:0] REG_POSITION_GAIN  = 3'd0;
    localparam logic [2:0] REG_VELOCITY_GAIN  = 3'd1;
    localparam logic [2:0] REG_VELOCITY_SCALE = 3'd2;
    localparam logic [2:0] REG_SMOOTHING_GAIN = 3'd3;
    localparam logic [2:0] REG_SPEED_LIMIT    = 3'd4;
    localparam logic [2:0] REG_SPEED_DEADBAND = 3'd5;
    localparam logic [2:0] REG_GAP_TIMEOUT    = 3'd6;

    localparam logic [19:0] RST_POSITION_GAIN  = 20'd59638;
    localparam logic [19:0] RST_VELOCITY_GAIN  = 20'd406546;
    localparam logic [19:0] RST_VELOCITY_SCALE = 20'd13107;
    localparam logic [16:0] RST_SMOOTHING_GAIN = 17'd65536;
    localparam logic [30:0] RST_SPEED_LIMIT    = 31'd32768;
    localparam logic [15:0] RST_SPEED_DEADBAND = 16'd655;
    localparam logic [17:0] RST_GAP_TIMEOUT    = 18'd16384;

    localparam logic [16:0] ONE_Q16 = 17'd65536;

    typedef struct packed {
        logic signed [31:0] measured_height;
        logic        [17:0] elapsed_time;
    } sample_t;

    typedef struct packed {
        logic signed [31:0] predicted_height;
        logic signed [31:0] velocity_estimate;
    } track_t;

endpackage

`default_nettype wire

// ===== rtl/alpha_beta_range_tracker.sv =====
// Alpha-beta range tracker top level with a bit-serial shift-add multiplier.
// Depends on abrt_pkg.
// Sequence: a sample accepted in idle runs the prediction, low-pass, alpha, gain and beta products, then finish.
// Flow: sample_stall holds off a new sample until the previous one has passed through the single serial
// multiplier (products of 18, 17, 17, 20, 20 and 24 bits, one multiplier bit per cycle).
// Reset: asynchronous, clears filter state to zero and loads default register values.
`default_nettype none

module alpha_beta_range_tracker (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         psel,
    input  wire logic                         penable,
    input  wire logic                         pwrite,
    input  wire logic [abrt_pkg::ADDR_W-1:0]  paddr,
    input  wire logic [abrt_pkg::DATA_W-1:0]  pwdata,
    output logic      [abrt_pkg::DATA_W-1:0]  prdata,
    output logic                              pready,
    input  wire logic                         sample_valid,
    output logic                              sample_stall,
    input  wire abrt_pkg::sample_t            sample,
    output logic                              track_valid,
    input  wire logic                         track_stall,
    output abrt_pkg::track_t                  track
);
    import abrt_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PRED,
        ST_LP1,
        ST_LP2,
        ST_ALPHA,
        ST_KB,
        ST_BETA,
        ST_FINISH
    } state_t;

    function automatic logic signed [31:0] sat32(input logic signed [60:0] x);
        if (x > 61'sd2147483647)
            return 32'sh7fffffff;
        else if (x < -61'sd2147483648)
            return 32'sh80000000;
        else
            return x[31:0];
    endfunction

    function automatic logic signed [43:0] rnd(input logic signed [59:0] a);
        logic signed [59:0] t;
        t = a + 60'sd32768;
        return t[59:16];
    endfunction

    function automatic logic signed [31:0] clamp_band(input logic signed [31:0] v,
                                                      input logic [30:0] lim,
                                                      input logic [15:0] db);
        logic signed [32:0] x;
        logic signed [32:0] l;
        logic signed [32:0] m;
        x = {v[31], v};
        l = {2'b00, lim};
        if (x > l)
            x = l;
        if (x < -l)
            x = -l;
        m = x[32] ? -x : x;
        if (m < $signed({17'd0, db}))
            x = 33'sd0;
        return x[31:0];
    endfunction

    state_t             state_reg, state_next;
    logic [19:0]        pos_gain_reg, pos_gain_next;
    logic [19:0]        vel_gain_reg, vel_gain_next;
    logic [19:0]        vel_scale_reg, vel_scale_next;
    logic [16:0]        smooth_reg, smooth_next;
    logic [30:0]        limit_reg, limit_next;
    logic [15:0]        band_reg, band_next;
    logic [17:0]        timeout_reg, timeout_next;

    logic signed [31:0] post_h_reg, post_h_next;
    logic signed [31:0] post_v_reg, post_v_next;
    logic signed [31:0] prev_v_reg, prev_v_next;

    logic signed [31:0] meas_reg, meas_next;
    logic signed [31:0] pred_reg, pred_next;
    logic signed [32:0] innov_reg, innov_next;
    logic signed [59:0] acc_reg, acc_next;
    logic signed [59:0] mc_reg, mc_next;
    logic [23:0]        mp_reg, mp_next;
    logic [4:0]         cnt_reg, cnt_next;
    logic               out_valid_reg, out_valid_next;
    track_t             out_reg, out_next;

    logic               wr_en;
    logic [2:0]         wr_idx;
    logic signed [59:0] acc_sum;
    logic               last_step;
    logic [16:0]        s_eff;
    logic signed [43:0] r;
    logic signed [31:0] vold;
    logic signed [31:0] vband;
    logic signed [31:0] newv;

    assign pready       = 1'b1;
    assign wr_en        = psel && penable && pwrite;
    assign wr_idx       = paddr[4:2];
    assign sample_stall = (state_reg != ST_IDLE);
    assign track_valid  = out_valid_reg;
    assign track        = out_reg;
    assign acc_sum      = acc_reg + (mp_reg[0] ? mc_reg : 60'sd0);
    assign last_step    = (cnt_reg == 5'd1);
    assign s_eff        = (smooth_reg > ONE_Q16) ? ONE_Q16 : smooth_reg;
    assign r            = rnd(acc_sum);
    assign vold         = (sample.elapsed_time > timeout_reg) ? 32'sd0 : prev_v_reg;
    assign vband        = clamp_band(post_v_reg, limit_reg, band_reg);
    assign newv         = r[31:0];

    always_comb
    begin
        unique case (paddr[4:2])
            REG_POSITION_GAIN:  prdata = {12'd0, pos_gain_reg};
            REG_VELOCITY_GAIN:  prdata = {12'd0, vel_gain_reg};
            REG_VELOCITY_SCALE: prdata = {12'd0, vel_scale_reg};
            REG_SMOOTHING_GAIN: prdata = {15'd0, smooth_reg};
            REG_SPEED_LIMIT:    prdata = {1'b0, limit_reg};
            REG_SPEED_DEADBAND: prdata = {16'd0, band_reg};
            REG_GAP_TIMEOUT:    prdata = {14'd0, timeout_reg};
            default:            prdata = '0;
        endcase
    end

    always_comb
    begin
        pos_gain_next  = pos_gain_reg;
        vel_gain_next  = vel_gain_reg;
        vel_scale_next = vel_scale_reg;
        smooth_next    = smooth_reg;
        limit_next     = limit_reg;
        band_next      = band_reg;
        timeout_next   = timeout_reg;
        if (wr_en)
        begin
            unique case (wr_idx)
                REG_POSITION_GAIN:  pos_gain_next  = pwdata[19:0];
                REG_VELOCITY_GAIN:  vel_gain_next  = pwdata[19:0];
                REG_VELOCITY_SCALE: vel_scale_next = pwdata[19:0];
                REG_SMOOTHING_GAIN: smooth_next    = pwdata[16:0];
                REG_SPEED_LIMIT:    limit_next     = pwdata[30:0];
                REG_SPEED_DEADBAND: band_next      = pwdata[15:0];
                REG_GAP_TIMEOUT:    timeout_next   = pwdata[17:0];
                default:            ;
            endcase
        end

        state_next     = state_reg;
        post_h_next    = post_h_reg;
        post_v_next    = post_v_reg;
        prev_v_next    = prev_v_reg;
        meas_next      = meas_reg;
        pred_next      = pred_reg;
        innov_next     = innov_reg;
        acc_next       = acc_sum;
        mc_next        = mc_reg <<< 1;
        mp_next        = mp_reg >> 1;
        cnt_next       = cnt_reg - 5'd1;
        out_valid_next = out_valid_reg;
        out_next       = out_reg;

        if (out_valid_reg && !track_stall)
            out_valid_next = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                acc_next = '0;
                mc_next  = mc_reg;
                mp_next  = mp_reg;
                cnt_next = cnt_reg;
                if (sample_valid)
                begin
                    meas_next  = sample.measured_height;
                    mc_next    = {{28{vold[31]}}, vold};
                    mp_next    = {6'd0, sample.elapsed_time};
                    cnt_next   = 5'd18;
                    state_next = ST_PRED;
                end
            end
            ST_PRED:
            begin
                if (last_step)
                begin
                    pred_next  = sat32({{29{post_h_reg[31]}}, post_h_reg}
                                       + {{17{r[43]}}, r});
                    acc_next   = '0;
                    mc_next    = {{28{prev_v_reg[31]}}, prev_v_reg};
                    mp_next    = {7'd0, ONE_Q16 - s_eff};
                    cnt_next   = 5'd17;
                    state_next = ST_LP1;
                end
            end
            ST_LP1:
            begin
                if (last_step)
                begin
                    mc_next    = {{28{vband[31]}}, vband};
                    mp_next    = {7'd0, s_eff};
                    cnt_next   = 5'd17;
                    state_next = ST_LP2;
                end
            end
            ST_LP2:
            begin
                if (last_step)
                begin
                    prev_v_next = newv;
                    innov_next  = {meas_reg[31], meas_reg} - {pred_reg[31], pred_reg};
                    acc_next    = '0;
                    mc_next     = {{27{innov_next[32]}}, innov_next};
                    mp_next     = {4'd0, pos_gain_reg};
                    cnt_next    = 5'd20;
                    state_next  = ST_ALPHA;
                end
            end
            ST_ALPHA:
            begin
                if (last_step)
                begin
                    post_h_next = sat32({{29{pred_reg[31]}}, pred_reg}
                                        + {{17{r[43]}}, r});
                    acc_next    = '0;
                    mc_next     = {40'd0, vel_gain_reg};
                    mp_next     = {4'd0, vel_scale_reg};
                    cnt_next    = 5'd20;
                    state_next  = ST_KB;
                end
            end
            ST_KB:
            begin
                if (last_step)
                begin
                    acc_next   = '0;
                    mc_next    = {{27{innov_reg[32]}}, innov_reg};
                    mp_next    = r[23:0];
                    cnt_next   = 5'd24;
                    state_next = ST_BETA;
                end
            end
            ST_BETA:
            begin
                if (last_step)
                begin
                    post_v_next = clamp_band(sat32({{29{prev_v_reg[31]}}, prev_v_reg}
                                                   + {{17{r[43]}}, r}),
                                             limit_reg, band_reg);
                    state_next  = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                acc_next = acc_reg;
                mc_next  = mc_reg;
                mp_next  = mp_reg;
                cnt_next = cnt_reg;
                if (!out_valid_reg || !track_stall)
                begin
                    out_next.predicted_height  = pred_reg;
                    out_next.velocity_estimate = post_v_reg;
                    out_valid_next             = 1'b1;
                    state_next                 = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            pos_gain_reg  <= RST_POSITION_GAIN;
            vel_gain_reg  <= RST_VELOCITY_GAIN;
            vel_scale_reg <= RST_VELOCITY_SCALE;
            smooth_reg    <= RST_SMOOTHING_GAIN;
            limit_reg     <= RST_SPEED_LIMIT;
            band_reg      <= RST_SPEED_DEADBAND;
            timeout_reg   <= RST_GAP_TIMEOUT;
            post_h_reg    <= '0;
            post_v_reg    <= '0;
            prev_v_reg    <= '0;
            meas_reg      <= '0;
            pred_reg      <= '0;
            innov_reg     <= '0;
            acc_reg       <= '0;
            mc_reg        <= '0;
            mp_reg        <= '0;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
            out_reg       <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            pos_gain_reg  <= pos_gain_next;
            vel_gain_reg  <= vel_gain_next;
            vel_scale_reg <= vel_scale_next;
            smooth_reg    <= smooth_next;
            limit_reg     <= limit_next;
            band_reg      <= band_next;
            timeout_reg   <= timeout_next;
            post_h_reg    <= post_h_next;
            post_v_reg    <= post_v_next;
            prev_v_reg    <= prev_v_next;
            meas_reg      <= meas_next;
            pred_reg      <= pred_next;
            innov_reg     <= innov_next;
            acc_reg       <= acc_next;
            mc_reg        <= mc_next;
            mp_reg        <= mp_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
            out_reg       <= out_next;
        end
    end

    a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
        (sample_valid && !sample_stall) |=> (state_reg == ST_PRED && cnt_reg == 5'd18))
        else $error("accepted word did not start the prediction product");

    a_result_from_finish: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(track_valid) |-> $past(state_reg == ST_FINISH))
        else $error("track word raised outside finish");

    a_velocity_clamped: assert property (@(posedge clk) disable iff (!rst_n)
        track_valid |-> (track.velocity_estimate <= $signed({1'b0, limit_reg})
                         && track.velocity_estimate >= -$signed({1'b0, limit_reg})))
        else $error("velocity word outside the speed limit");

endmodule

`default_nettype wire
